/* design/hms_pkg.sv */
// shared constants, types and functions for the hmac-sha256 block
package hms_pkg;

    localparam int unsigned KeyRegs = 4;
    localparam logic [1:0]  KeyIdx0 = 2'd0;
    localparam logic [1:0]  KeyIdx1 = 2'd1;
    localparam logic [1:0]  KeyIdx2 = 2'd2;
    localparam logic [1:0]  KeyIdx3 = 2'd3;
    localparam logic [7:0]  IpadByte = 8'h36;
    localparam logic [7:0]  OpadByte = 8'h5c;
    localparam logic [7:0]  PadByte  = 8'h80;
    localparam logic [5:0]  LenPos   = 6'd56;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic  start;
        t_word w0;
    } t_rnd_ctl;

    function automatic t_word f_k(input logic [5:0] r);
        t_word k;
        case (r)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word f_iv(input logic [2:0] i);
        t_word h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage

/* design/hms_compress.sv */
// sha-256 compression, one round per cycle, block words streamed in while o_need_w is high
module hms_compress (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hms_pkg::t_rnd_ctl i_ctl,
    input  hms_pkg::t_word   i_w,
    input  logic             i_init,
    output logic             o_need_w,
    output logic             o_busy,
    output logic             o_done,
    output hms_pkg::t_word   o_h [8]
);
    import hms_pkg::*;

    t_word r_h [8];
    t_word r_v [8];
    t_word r_s [16];
    logic [5:0] r_rnd;
    logic r_busy;
    logic r_fold;

    t_word w, x, y, t1, t2, e, a;
    logic [3:0] ri;

    assign ri = r_rnd[3:0];
    assign o_need_w = r_busy && (r_rnd < 6'd16);
    assign o_busy = r_busy || r_fold;

    always_comb begin
        x = r_s[ri + 4'd1];
        y = r_s[ri + 4'd14];
        if (r_rnd < 6'd16) begin
            w = (r_rnd == 6'd0) ? i_ctl.w0 : i_w;
        end else begin
            w = r_s[ri] + ({x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3))
                + r_s[ri + 4'd9]
                + ({y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10));
        end
        e = r_v[4];
        a = r_v[0];
        t1 = r_v[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
             + ((e & r_v[5]) ^ (~e & r_v[6])) + f_k(r_rnd) + w;
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
             + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
            r_busy <= 1'b0;
            r_fold <= 1'b0;
            r_rnd <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= f_iv(3'(i));
        end else begin
            o_done <= r_fold && !r_busy;
            if (i_init) begin
                for (int i = 0; i < 8; i++) r_h[i] <= f_iv(3'(i));
            end
            if (i_ctl.start && !r_busy && !r_fold) begin
                r_busy <= 1'b1;
                r_rnd <= '0;
                for (int i = 0; i < 8; i++) r_v[i] <= i_init ? f_iv(3'(i)) : r_h[i];
            end else if (r_busy) begin
                r_s[ri] <= w;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fold <= 1'b1;
                end
            end else if (r_fold) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                r_fold <= 1'b0;
            end
        end
    end

    assign o_h = r_h;

    a_fold_after_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_rnd == 6'd63 |=> r_fold && !r_busy)
        else $error("fold missed");
    a_done_after_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fold |=> o_done)
        else $error("done missed");
    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_fold))
        else $error("busy and fold together");
endmodule

/* design/hmac_sha256_mac.sv */
// hmac-sha256 top level: key registers, byte buffer, padding sequencer and mac output
// usage:
//   write the key through i_cfg_we / i_cfg_index / i_cfg_data (four 64-bit words,
//   key byte 0 in the top bits of word 0) while the block is idle.
//   input beats carry one optional message byte and a last flag. the first beat
//   of a message first hashes the inner key block. a beat that fills a 64-byte
//   block adds a compression (one sha-256 round per cycle in the shared round
//   unit plus fold and done).
//   a last beat runs the inner finish (one or two compressions), the outer key
//   block and the outer finish, then eight result beats, word_index 0..7,
//   final_word on the eighth.
//   i_stall on the output holds the current word; the input stays stalled
//   until all eight words are taken.
//   reset restores the sha-256 initial values and closes any open message;
//   the key registers clear to zero. the block buffer is not cleared.
module hmac_sha256_mac (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_mac_word,
    output logic [2:0]  o_word_index,
    output logic        o_final_word
);
    import hms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_KEY, S_KWAIT, S_BYTE, S_BWAIT, S_PAD, S_PWAIT,
        S_OUTER, S_OWAIT, S_DIG, S_SEND
    } t_state;

    t_state r_state;
    logic [63:0] r_key [KeyRegs];
    t_word       r_buf [16];
    logic [63:0] r_len;
    logic [5:0]  r_pos;
    logic        r_open;
    logic        r_outer;
    logic        r_last;
    logic        r_has;
    logic [7:0]  r_byte;
    logic        r_pad;
    logic [1:0]  r_kpad_sel;
    logic [3:0]  r_wi;
    t_word       r_dig [8];
    t_word       r_word;
    logic [2:0]  r_oi;
    logic        r_kblk, r_pad2;

    t_rnd_ctl ctl;
    t_word    cw;
    logic     need_w, cbusy, cdone;
    t_word    h [8];
    logic [7:0] kpad;
    logic [63:0] bits;
    logic        key_init;
    logic [5:0]  pad_pos;
    t_word       wsel;

    assign kpad = r_kpad_sel[0] ? OpadByte : IpadByte;
    assign bits = {r_len[60:0], 3'b000};
    assign key_init = (r_state == S_KEY);
    assign pad_pos = r_has ? r_pos + 6'd1 : r_pos;

    function automatic logic [7:0] key_byte(input logic [5:0] i, input logic [63:0] kw,
                                            input logic [7:0] p);
        logic [7:0] kb;
        kb = i[5] ? 8'h00 : kw[{~i[2:0], 3'b000} +: 8];
        return kb ^ p;
    endfunction

    // word source for the round unit
    always_comb begin
        t_word      bw;
        logic [5:0] j;
        logic [7:0] sb;
        bw = r_buf[r_wi];
        for (int n = 0; n < 4; n++) begin
            j = {r_wi, 2'(n)};
            if (r_kblk) sb = key_byte(j, r_key[j[4:3]], kpad);
            else if (!r_pad) sb = bw[31 - 8*n -: 8];
            else if (j >= LenPos && !r_pad2) sb = bits[{~j[2:0], 3'b000} +: 8];
            else if (j <= r_pos) sb = bw[31 - 8*n -: 8];
            else sb = 8'h00;
            wsel[31 - 8*n -: 8] = sb;
        end
    end

    assign cw = wsel;
    assign ctl.w0 = wsel;
    assign ctl.start = (r_state == S_KEY) || (r_state == S_BYTE && r_pos == 6'd63 && r_has)
                       || (r_state == S_PAD);

    hms_compress u_cmp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_w(cw), .i_init(key_init),
        .o_need_w(need_w), .o_busy(cbusy), .o_done(cdone), .o_h(h)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_SEND);
    assign o_mac_word = r_word;
    assign o_word_index = r_oi;
    assign o_final_word = (r_oi == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KeyRegs; i++) r_key[i] <= '0;
            r_state <= S_IDLE;
            r_open <= 1'b0;
            r_len <= '0;
            r_pos <= '0;
            r_oi <= '0;
        end else begin
            if (i_cfg_we) r_key[i_cfg_index] <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_has <= i_has_byte;
                        r_byte <= i_data_byte;
                        r_last <= i_last;
                        r_outer <= 1'b0;
                        r_pad <= 1'b0;
                        if (!r_open) begin
                            r_kblk <= 1'b1;
                            r_kpad_sel <= 2'd0;
                            r_state <= S_KEY;
                        end else begin
                            r_state <= S_BYTE;
                        end
                    end
                end
                S_KEY: begin
                    r_wi <= 4'd0;
                    r_state <= S_KWAIT;
                end
                S_KWAIT: begin
                    if (need_w) r_wi <= r_wi + 4'd1;
                    if (cdone) begin
                        r_kblk <= 1'b0;
                        r_len <= 64'd64;
                        r_pos <= '0;
                        r_open <= 1'b1;
                        r_state <= r_outer ? S_DIG : S_BYTE;
                    end
                end
                S_BYTE: begin
                    if (r_has) begin
                        r_buf[r_pos[5:2]][{~r_pos[1:0], 3'b000} +: 8] <= r_byte;
                        r_len <= r_len + 64'd1;
                        r_pos <= r_pos + 6'd1;
                    end
                    r_has <= 1'b0;
                    r_wi <= 4'd0;
                    if (r_has && r_pos == 6'd63) r_state <= S_BWAIT;
                    else if (r_last) r_state <= S_PAD;
                    else r_state <= S_IDLE;
                    if (r_has && r_pos == 6'd63) r_pad <= 1'b0;
                    else if (r_last) begin
                        r_pad <= 1'b1;
                        r_pad2 <= (pad_pos >= 6'd56);
                        r_buf[pad_pos[5:2]][{~pad_pos[1:0], 3'b000} +: 8] <= PadByte;
                    end
                end
                S_BWAIT: begin
                    if (need_w) r_wi <= r_wi + 4'd1;
                    if (cdone) begin
                        r_state <= r_last ? S_PAD : S_IDLE;
                        if (r_last) begin
                            r_pad <= 1'b1;
                            r_pad2 <= 1'b0;
                            r_buf[0][31:24] <= PadByte;
                        end
                    end
                end
                S_PAD: begin
                    r_wi <= 4'd0;
                    r_state <= S_PWAIT;
                end
                S_PWAIT: begin
                    if (need_w) r_wi <= r_wi + 4'd1;
                    if (cdone) begin
                        if (r_pad2) begin
                            r_pad2 <= 1'b0;
                            r_pos <= '0;
                            r_buf[0][31:24] <= 8'h00;
                            r_state <= S_PAD;
                        end else if (!r_outer) begin
                            for (int i = 0; i < 8; i++) r_dig[i] <= h[i];
                            r_state <= S_OUTER;
                        end else begin
                            r_oi <= '0;
                            r_word <= h[0];
                            r_state <= S_SEND;
                        end
                    end
                end
                S_OUTER: begin
                    r_outer <= 1'b1;
                    r_kblk <= 1'b1;
                    r_kpad_sel <= 2'd1;
                    r_pad <= 1'b0;
                    r_state <= S_KEY;
                end
                S_DIG: begin
                    for (int i = 0; i < 8; i++) r_buf[i] <= r_dig[i];
                    r_buf[8][31:24] <= PadByte;
                    r_pos <= 6'd32;
                    r_len <= 64'd96;
                    r_pad <= 1'b1;
                    r_pad2 <= 1'b0;
                    r_state <= S_PAD;
                end
                S_SEND: begin
                    if (!i_stall) begin
                        r_oi <= r_oi + 3'd1;
                        r_word <= h[r_oi + 3'd1];
                        if (r_oi == 3'd7) begin
                            r_open <= 1'b0;
                            r_len <= '0;
                            r_pos <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cbusy |-> o_stall)
        else $error("input open while compressing");
    a_send_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !cbusy)
        else $error("output while compressing");
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_final_word |=> r_state == S_IDLE && !r_open)
        else $error("no close after last word");
endmodule

/* sim/testbench.sv */
// hmac-sha256 mac testbench: model-based prediction of eight mac words per message
module testbench;
    import hms_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_has_byte;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_mac_word;
    logic [2:0]  o_word_index;
    logic        o_final_word;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } t_mac_beat;

    hmac_sha256_mac i_dut (.*);

    // predictor state
    logic [63:0] key_regs [KeyRegs];
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    logic [63:0] msg_len;
    logic        msg_open;
    t_mac_beat   mac_queue [$];
    int          errors;
    bit          quiet;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + f_k(r[5:0]) + w[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endtask

    task automatic hash_key_block(input logic [7:0] pad);
        logic [7:0] kb;
        for (int i = 0; i < 8; i++) chain[i] = f_iv(i[2:0]);
        for (int i = 0; i < 64; i++) begin
            kb = (i < 32) ? key_regs[i/8][63 - 8*(i%8) -: 8] : 8'h00;
            blk[i] = kb ^ pad;
        end
        sha_compress();
        msg_len = 64;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        blk[msg_len[5:0]] = b;
        msg_len++;
        if (msg_len[5:0] == 0) sha_compress();
    endtask

    task automatic pad_and_close();
        logic [63:0] bits;
        int pos;
        bits = msg_len << 3;
        pos = msg_len[5:0];
        blk[pos++] = PadByte;
        if (pos > LenPos) begin
            while (pos < 64) blk[pos++] = 8'h00;
            sha_compress();
            pos = 0;
        end
        while (pos < LenPos) blk[pos++] = 8'h00;
        for (int i = 0; i < 8; i++) blk[56+i] = bits[63 - 8*i -: 8];
        sha_compress();
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic hb, input logic lst);
        logic [31:0] inner [8];
        if (!msg_open) begin
            hash_key_block(IpadByte);
            msg_open = 1;
        end
        if (hb) absorb_byte(b);
        if (lst) begin
            pad_and_close();
            for (int i = 0; i < 8; i++) inner[i] = chain[i];
            hash_key_block(OpadByte);
            for (int i = 0; i < 32; i++) absorb_byte(inner[i/4][31 - 8*(i%4) -: 8]);
            pad_and_close();
            for (int i = 0; i < 8; i++) mac_queue.push_back({chain[i], i[2:0], i == 7});
            msg_open = 0;
            msg_len = 0;
        end
    endtask

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("TB_ERROR");
        $finish;
    end

    // result checker and output stall
    always @(posedge i_clk) begin
        t_mac_beat got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_mac_word, o_word_index, o_final_word};
            if (mac_queue.size() == 0) begin
                $display("%0t unexpected beat: actual %h", $time, got);
                errors++;
            end else begin
                want = mac_queue.pop_front();
                if (got.word !== want.word) begin
                    $display("%0t mac_word: expected %h actual %h", $time, want.word, got.word);
                    errors++;
                end
                if (got.idx !== want.idx) begin
                    $display("%0t word_index: expected %0d actual %0d", $time, want.idx, got.idx);
                    errors++;
                end
                if (got.fin !== want.fin) begin
                    $display("%0t final_word: expected %0d actual %0d", $time, want.fin, got.fin);
                    errors++;
                end
            end
        end
    end

    int stall_left;
    always @(posedge i_clk) begin
        if (quiet) begin
            i_stall <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            i_stall <= 1;
        end else begin
            i_stall <= 0;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic hb, input logic lst);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_data_byte <= b;
        i_has_byte <= hb;
        i_last <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_beat(b, hb, lst);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (mac_queue.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        key_regs[idx] = val;
    endtask

    task automatic write_key_words(input logic [63:0] k0, input logic [63:0] k1,
                                   input logic [63:0] k2, input logic [63:0] k3);
        write_key(KeyIdx0, k0);
        write_key(KeyIdx1, k1);
        write_key(KeyIdx2, k2);
        write_key(KeyIdx3, k3);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_message(input int n, input logic tail_empty);
        for (int i = 0; i < n; i++)
            send_beat(8'($urandom_range(0, 255)), 1'b1, !tail_empty && i == n - 1);
        if (tail_empty || n == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic test_reset_key();
        send_beat(8'h00, 0, 1);
        send_beat(8'hff, 1, 1);
        send_beat(8'h00, 1, 1);
        drain();
    endtask

    task automatic test_key_extremes();
        write_key_words('1, '1, '1, '1);
        send_beat(8'h5a, 1, 0);
        send_beat(8'ha5, 0, 0);
        send_beat(8'h3c, 1, 1);
        drain();
        write_key_words(64'h0123456789abcdef, 64'hfedcba9876543210,
                        64'h8000000000000001, 64'h0);
        // padding spills into a second block
        send_message(56, 1);
        drain();
        // last byte fills a block
        send_message(64, 0);
        drain();
    endtask

    task automatic test_random();
        int n;
        for (int m = 0; m < 8; m++) begin
            if (m % 4 == 0) begin
                write_key_words({$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom}, {$urandom, $urandom});
            end
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0, 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            if (m % 4 == 3) drain();
        end
        drain();
    endtask

    task automatic test_no_idle();
        quiet = 1;
        for (int m = 0; m < 3; m++)
            send_message($urandom_range(1, 8), 1'($urandom_range(0, 1)));
        drain();
    endtask

    initial begin
        errors = 0;
        quiet = 0;
        stall_left = 0;
        msg_open = 0;
        msg_len = 0;
        for (int k = 0; k < KeyRegs; k++) key_regs[k] = '0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = KeyIdx0;
        i_cfg_data = '0;
        i_valid = 0;
        i_data_byte = '0;
        i_has_byte = 0;
        i_last = 0;
        i_stall = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_reset_key();
        test_key_extremes();
        test_random();
        test_no_idle();
        if (errors == 0 && mac_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
